// ===== rtl/block_deframer_checksum_check_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the block deframer
// Shared property wrappers that clock on clk and report through $error.
// ----------------------------------------------------------------------------
`ifndef BLOCK_DEFRAMER_CHECKSUM_CHECK_ASSERT_SVH
`define BLOCK_DEFRAMER_CHECKSUM_CHECK_ASSERT_SVH

// Checked only while reset is released.
`define DCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, including during reset.
`define DCC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Block deframer package
// Transaction types, phase encoding and verdict codes of the deframer.
// ----------------------------------------------------------------------------
package dcc_pkg;

    localparam int HEADER_BYTES = 16;
    localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;

    localparam logic [1:0] VERDICT_ACCEPTED = 2'd0;
    localparam logic [1:0] VERDICT_CSUM_ERR = 2'd1;
    localparam logic [1:0] VERDICT_DROPPED  = 2'd2;
    localparam logic [1:0] VERDICT_DONE     = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HEADER,
        PH_PAYLOAD,
        PH_HALTED,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        verdict_valid;
        logic [1:0]  verdict;
        logic        send_ack;
        logic        send_nack;
        logic [31:0] block_number;
        logic [31:0] block_length;
        logic [30:0] total_accepted;
    } out_item_t;

endpackage

// ===== rtl/dcc_core.sv =====
// ----------------------------------------------------------------------------
// Deframer core
// Session state and the per-byte sync, header, payload and verdict logic.
// ----------------------------------------------------------------------------
module dcc_core
    import dcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] magic_word,
    input  in_item_t    item,
    input  logic        fire,
    output logic        has_result,
    output out_item_t   result
);

    localparam logic [2:0] SYNC_BYTES = 3'd4;
    localparam logic [3:0] HDR_LAST   = 4'(HEADER_BYTES - 5);
    localparam logic [3:0] SEQ_END    = 4'd4;
    localparam logic [3:0] SIZE_END   = 4'd8;

    phase_t      phase_reg, phase_next;
    logic [31:0] window_reg, window_next;
    logic [2:0]  fill_reg, fill_next;
    logic [3:0]  fbc_reg, fbc_next;
    logic [31:0] hseq_reg, hseq_next;
    logic [31:0] hsize_reg, hsize_next;
    logic [31:0] hsum_reg, hsum_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] rsum_reg, rsum_next;
    logic [31:0] expseq_reg, expseq_next;
    logic [30:0] acc_reg, acc_next;

    logic [32:0] acc_sum;
    logic        inseq;

    assign acc_sum = {2'b00, acc_reg} + {1'b0, hsize_reg};
    assign inseq   = (hseq_reg == expseq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            window_reg <= '0;
            fill_reg   <= '0;
            fbc_reg    <= '0;
            hseq_reg   <= '0;
            hsize_reg  <= '0;
            hsum_reg   <= '0;
            left_reg   <= '0;
            rsum_reg   <= '0;
            expseq_reg <= '0;
            acc_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            fill_reg   <= fill_next;
            fbc_reg    <= fbc_next;
            hseq_reg   <= hseq_next;
            hsize_reg  <= hsize_next;
            hsum_reg   <= hsum_next;
            left_reg   <= left_next;
            rsum_reg   <= rsum_next;
            expseq_reg <= expseq_next;
            acc_reg    <= acc_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        window_next = window_reg;
        fill_next   = fill_reg;
        fbc_next    = fbc_reg;
        hseq_next   = hseq_reg;
        hsize_next  = hsize_reg;
        hsum_next   = hsum_reg;
        left_next   = left_reg;
        rsum_next   = rsum_reg;
        expseq_next = expseq_reg;
        acc_next    = acc_reg;
        result      = '0;

        if (item.restart)
        begin
            phase_next  = PH_HUNT;
            window_next = '0;
            fill_next   = '0;
            fbc_next    = '0;
            hseq_next   = '0;
            hsize_next  = '0;
            hsum_next   = '0;
            left_next   = '0;
            rsum_next   = '0;
            expseq_next = '0;
            acc_next    = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    window_next = {window_reg[23:0], item.data_byte};
                    if (fill_reg < SYNC_BYTES)
                    begin
                        fill_next = fill_reg + 3'd1;
                    end
                    if (fill_next == SYNC_BYTES && window_next == magic_word)
                    begin
                        phase_next = PH_HEADER;
                        fbc_next   = '0;
                    end
                end
                PH_HEADER:
                begin
                    if (fbc_reg < SEQ_END)
                    begin
                        hseq_next = {hseq_reg[23:0], item.data_byte};
                    end
                    else if (fbc_reg < SIZE_END)
                    begin
                        hsize_next = {hsize_reg[23:0], item.data_byte};
                    end
                    else
                    begin
                        hsum_next = {hsum_reg[23:0], item.data_byte};
                    end
                    fbc_next = fbc_reg + 4'd1;
                    if (fbc_reg == HDR_LAST)
                    begin
                        fbc_next  = '0;
                        rsum_next = '0;
                        left_next = hsize_next;
                        if (hsize_next != '0)
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                        else
                        begin
                            result.verdict_valid = 1'b1;
                            result.block_number  = hseq_next;
                            result.block_length  = hsize_next;
                            if (hsum_next != '0)
                            begin
                                result.verdict   = VERDICT_CSUM_ERR;
                                result.send_nack = 1'b1;
                                phase_next       = PH_HALTED;
                            end
                            else
                            begin
                                result.verdict  = VERDICT_DONE;
                                result.send_ack = (hseq_next == expseq_reg);
                                phase_next      = PH_DONE;
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    rsum_next            = rsum_reg + {24'd0, item.data_byte};
                    left_next            = left_reg - 32'd1;
                    result.payload_valid = inseq;
                    if (inseq)
                    begin
                        result.payload_byte = item.data_byte;
                    end
                    if (left_next == '0)
                    begin
                        result.verdict_valid = 1'b1;
                        result.block_number  = hseq_reg;
                        result.block_length  = hsize_reg;
                        if (rsum_next != hsum_reg)
                        begin
                            result.verdict   = VERDICT_CSUM_ERR;
                            result.send_nack = 1'b1;
                            phase_next       = PH_HALTED;
                        end
                        else
                        begin
                            if (inseq)
                            begin
                                acc_next = (acc_sum > {2'b00, COUNT_MAX}) ? COUNT_MAX
                                                                          : acc_sum[30:0];
                                expseq_next     = expseq_reg + 32'd1;
                                result.verdict  = VERDICT_ACCEPTED;
                                result.send_ack = 1'b1;
                            end
                            else
                            begin
                                result.verdict = VERDICT_DROPPED;
                            end
                            phase_next  = PH_HUNT;
                            window_next = '0;
                            fill_next   = '0;
                            fbc_next    = '0;
                        end
                    end
                end
                PH_HALTED, PH_DONE:
                begin
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        result.total_accepted = acc_next;
        has_result = result.payload_valid | result.verdict_valid;
    end

endmodule

// ===== rtl/block_deframer_checksum_check.sv =====
// Path: an accepted input is held in the input register; its result is registered
// into the result register once that register is free.
// Throughput: one byte per cycle; the input register, the core logic and the result
// register form a two-stage path that stalls only when a result meets a full slot.
// Reset: rst_n clears all session state, both stage valids and the sync word to zero.
// ----------------------------------------------------------------------------
// Block deframer with additive checksum check
// Hunts for the sync word, parses the header, sums the payload and reports
// one verdict per block.
// ----------------------------------------------------------------------------
module block_deframer_checksum_check
    import dcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);

    logic [31:0] magic_reg;
    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;

    logic        has_result;
    out_item_t   result;
    logic        out_free;
    logic        advance;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = in_valid_reg && (!has_result || out_free);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    dcc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .magic_word (magic_reg),
        .item       (in_item_reg),
        .fire       (advance),
        .has_result (has_result),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                magic_reg <= cfg_data;
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance && has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
        if (advance && has_result)
        begin
            out_item_reg <= result;
        end
    end

endmodule

// ===== rtl/dcc_checker.sv =====
// ----------------------------------------------------------------------------
// Deframer port checker
// Watches the result channel of the deframer over time.
// ----------------------------------------------------------------------------
`include "block_deframer_checksum_check_assert.svh"

module dcc_checker
    import dcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data
);

    `DCC_ASSERT_ALWAYS(a_idle_in_reset, !rst_n |-> !out_valid, "result valid during reset")

    `DCC_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result transaction changed")

    `DCC_ASSERT(a_not_empty, out_valid |-> out_data.payload_valid || out_data.verdict_valid, "result transaction carries nothing")

    `DCC_ASSERT(a_nack_is_error, out_valid && out_data.send_nack |-> out_data.verdict_valid && out_data.verdict == VERDICT_CSUM_ERR && !out_data.send_ack, "NACK without checksum error verdict")

endmodule

bind block_deframer_checksum_check dcc_checker u_dcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
